// ===== rtl/knn_pkg.sv =====
// Shared constants, payload types and helpers for the k-nearest-neighbor insert unit.
`default_nettype none

package knn_pkg;

    localparam int MAX_DIMS      = 8;
    localparam int MAX_NEIGHBORS = 16;
    localparam int COORD_BITS    = 16;
    localparam int ID_BITS       = 24;

    localparam int FUNC_BITS = 2;
    localparam int DIMS_BITS = 4;
    localparam int K_BITS    = 5;
    localparam int RANK_BITS = 4;
    localparam int CFG_BITS  = 5;
    localparam int SQ_BITS   = 2 * COORD_BITS;
    localparam int PAIR_BITS = SQ_BITS + 1;
    localparam int DIST_BITS = 35;
    localparam int PAIRS     = MAX_DIMS / 2;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_QUERY  = 2'd0,
        FUNC_CAND   = 2'd1,
        FUNC_REPORT = 2'd2
    } func_t;

    localparam logic CFG_DIMS      = 1'b0;
    localparam logic CFG_NEIGHBORS = 1'b1;

    typedef struct packed {
        logic [FUNC_BITS-1:0]         func;
        logic [ID_BITS-1:0]           point_id;
        logic signed [COORD_BITS-1:0] coord0;
        logic signed [COORD_BITS-1:0] coord1;
        logic signed [COORD_BITS-1:0] coord2;
        logic signed [COORD_BITS-1:0] coord3;
        logic signed [COORD_BITS-1:0] coord4;
        logic signed [COORD_BITS-1:0] coord5;
        logic signed [COORD_BITS-1:0] coord6;
        logic signed [COORD_BITS-1:0] coord7;
    } knn_item_t;

    typedef struct packed {
        logic [RANK_BITS-1:0] rank;
        logic [ID_BITS-1:0]   neighbor_id;
        logic [DIST_BITS-1:0] neighbor_sq_dist;
        logic                 neighbor_valid;
        logic                 last;
    } knn_result_t;

    typedef struct packed {
        logic                 valid;
        logic [ID_BITS-1:0]   id;
        logic [DIST_BITS-1:0] sq_dist;
    } knn_entry_t;

    // A register value of zero counts as one, values above the maximum as the maximum.
    function automatic logic [DIMS_BITS-1:0] eff_dims(input logic [DIMS_BITS-1:0] value);
        logic [DIMS_BITS-1:0] res;
        res = value;
        if (value == '0)
            res = DIMS_BITS'(1);
        else if (value > DIMS_BITS'(MAX_DIMS))
            res = DIMS_BITS'(MAX_DIMS);
        return res;
    endfunction

    function automatic logic [K_BITS-1:0] eff_k(input logic [K_BITS-1:0] value);
        logic [K_BITS-1:0] res;
        res = value;
        if (value == '0)
            res = K_BITS'(1);
        else if (value > K_BITS'(MAX_NEIGHBORS))
            res = K_BITS'(MAX_NEIGHBORS);
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/knn_dist_lane.sv =====
// One distance lane: coordinate difference and its square, registered.
`default_nettype none

module knn_dist_lane
    import knn_pkg::*;
(
    input  logic                         clk,
    input  logic                         advance,
    input  logic                         lane_on,
    input  logic signed [COORD_BITS-1:0] coord,
    input  logic signed [COORD_BITS-1:0] query,
    output logic [SQ_BITS-1:0]           sq_reg
);

    logic signed [COORD_BITS:0] diff;
    logic [COORD_BITS:0]        neg;
    logic [COORD_BITS-1:0]      mag;
    logic [SQ_BITS-1:0]         sq_next;

    always_comb
    begin
        diff = {coord[COORD_BITS-1], coord} - {query[COORD_BITS-1], query};
        neg  = -diff;
        // The magnitude of a 17-bit difference of two 16-bit values fits in 16 bits.
        mag  = diff[COORD_BITS] ? neg[COORD_BITS-1:0] : diff[COORD_BITS-1:0];
        sq_next = lane_on ? (SQ_BITS'(mag) * SQ_BITS'(mag)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            sq_reg <= sq_next;
    end

endmodule

`default_nettype wire

// ===== rtl/knn_sum_tree.sv =====
// Two-level registered adder tree that merges the lane squares into one distance.
`default_nettype none

module knn_sum_tree
    import knn_pkg::*;
(
    input  logic                 clk,
    input  logic                 advance,
    input  logic [SQ_BITS-1:0]   sq [MAX_DIMS],
    output logic [DIST_BITS-1:0] dist_reg
);

    logic [PAIR_BITS-1:0] pair_reg  [PAIRS];
    logic [PAIR_BITS-1:0] pair_next [PAIRS];
    logic [DIST_BITS-1:0] dist_next;

    always_comb
    begin
        for (int i = 0; i < PAIRS; i++)
            pair_next[i] = PAIR_BITS'(sq[2*i]) + PAIR_BITS'(sq[2*i+1]);
        dist_next = '0;
        for (int i = 0; i < PAIRS; i++)
            dist_next = dist_next + DIST_BITS'(pair_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pair_reg <= pair_next;
            dist_reg <= dist_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/knn_topk_list.sv =====
// Sorted neighbor list with a parallel-compare insert.
`default_nettype none

module knn_topk_list
    import knn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 insert,
    input  logic [ID_BITS-1:0]   cand_id,
    input  logic [DIST_BITS-1:0] cand_dist,
    input  logic [RANK_BITS-1:0] k_last,
    output knn_entry_t           entries [MAX_NEIGHBORS]
);

    logic [MAX_NEIGHBORS-1:0] valid_reg;
    logic [MAX_NEIGHBORS-1:0] valid_next;
    logic [ID_BITS-1:0]       id_reg    [MAX_NEIGHBORS];
    logic [ID_BITS-1:0]       id_next   [MAX_NEIGHBORS];
    logic [DIST_BITS-1:0]     dist_reg  [MAX_NEIGHBORS];
    logic [DIST_BITS-1:0]     dist_next [MAX_NEIGHBORS];

    logic [MAX_NEIGHBORS-1:0] hit;
    logic [MAX_NEIGHBORS-1:0] seen;
    logic                     drop;
    logic [MAX_NEIGHBORS-1:0] sh_valid;
    logic [ID_BITS-1:0]       sh_id   [MAX_NEIGHBORS];
    logic [DIST_BITS-1:0]     sh_dist [MAX_NEIGHBORS];

    always_comb
    begin
        // An entry is a slot for the candidate if it is empty or strictly farther.
        // The last kept slot is always a slot, as the fallback position.
        for (int i = 0; i < MAX_NEIGHBORS; i++)
            hit[i] = ((!valid_reg[i] || dist_reg[i] > cand_dist) && RANK_BITS'(i) < k_last)
                     || RANK_BITS'(i) == k_last;

        seen[0] = 1'b0;
        for (int i = 1; i < MAX_NEIGHBORS; i++)
            seen[i] = seen[i-1] | hit[i-1];

        drop = valid_reg[k_last] && !(cand_dist < dist_reg[k_last]);

        sh_valid[0] = 1'b1;
        sh_id[0]    = cand_id;
        sh_dist[0]  = cand_dist;
        for (int i = 1; i < MAX_NEIGHBORS; i++)
        begin
            sh_valid[i] = valid_reg[i-1];
            sh_id[i]    = id_reg[i-1];
            sh_dist[i]  = dist_reg[i-1];
        end

        valid_next = valid_reg;
        id_next    = id_reg;
        dist_next  = dist_reg;
        if (clear)
            valid_next = '0;
        else if (insert && !drop)
        begin
            for (int i = 0; i < MAX_NEIGHBORS; i++)
            begin
                if (RANK_BITS'(i) <= k_last)
                begin
                    if (seen[i])
                    begin
                        valid_next[i] = sh_valid[i];
                        id_next[i]    = sh_id[i];
                        dist_next[i]  = sh_dist[i];
                    end
                    else if (hit[i])
                    begin
                        valid_next[i] = 1'b1;
                        id_next[i]    = cand_id;
                        dist_next[i]  = cand_dist;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        dist_reg <= dist_next;
    end

    always_comb
    begin
        for (int i = 0; i < MAX_NEIGHBORS; i++)
        begin
            entries[i].valid   = valid_reg[i];
            entries[i].id      = id_reg[i];
            entries[i].sq_dist = dist_reg[i];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/knn_report.sv =====
// Report buffer: snapshots the list and streams it out one entry per cycle while result_ready is high.
`default_nettype none

module knn_report
    import knn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  knn_entry_t           entries [MAX_NEIGHBORS],
    input  logic [RANK_BITS-1:0] k_last,
    input  logic                 result_ready,
    output logic                 result_valid,
    output knn_result_t          result,
    output logic                 free
);

    logic                 active_reg;
    logic                 active_next;
    logic [RANK_BITS-1:0] idx_reg;
    logic [RANK_BITS-1:0] idx_next;
    knn_entry_t           shadow_reg [MAX_NEIGHBORS];
    knn_entry_t           cur;
    logic                 at_end;

    always_comb
    begin
        cur    = shadow_reg[idx_reg];
        at_end = (idx_reg == k_last);
        free   = !active_reg || (result_ready && at_end);

        result_valid            = active_reg;
        result.rank             = idx_reg;
        result.neighbor_id      = cur.valid ? cur.id : '0;
        result.neighbor_sq_dist = cur.valid ? cur.sq_dist : '0;
        result.neighbor_valid   = cur.valid;
        result.last             = at_end;

        active_next = active_reg;
        idx_next    = idx_reg;
        if (load)
        begin
            active_next = 1'b1;
            idx_next    = '0;
        end
        else if (active_reg && result_ready)
        begin
            if (at_end)
                active_next = 1'b0;
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            shadow_reg <= entries;
    end

endmodule

`default_nettype wire

// ===== rtl/knn_topk_distance_insert_unit.sv =====
// Top level of the k-nearest-neighbor distance and sorted-insert unit.
//
//   Channel   Signals                            Moves
//   item      item_valid / item_ready / item     query, candidate or report request
//   result    result_valid / result_ready / result   one list entry per beat
//   config    cfg_write / cfg_index / cfg_data   register write, no handshake
//
// A request is taken every cycle unless a blocked report holds the pipeline; it passes
// lane squares, a pair-add stage and a final-add stage, and then acts on the list.
// A report copies the list into the report buffer and streams k entries, one per cycle while result_ready is high.
// A report reaching the list while the previous report still has entries to send
// holds item_ready low until that run's last entry is taken.
// Reset empties the list, zeroes the query, and sets eight dimensions and sixteen neighbors.
`default_nettype none

module knn_topk_distance_insert_unit
    import knn_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    input  logic                item_valid,
    output logic                item_ready,
    input  knn_item_t           item,
    output logic                result_valid,
    input  logic                result_ready,
    output knn_result_t         result
);

    logic [DIMS_BITS-1:0] dims_reg;
    logic [K_BITS-1:0]    k_reg;
    logic [DIMS_BITS-1:0] dims_eff;
    logic [K_BITS-1:0]    k_eff;
    logic [RANK_BITS-1:0] k_last;

    logic signed [COORD_BITS-1:0] query_reg [MAX_DIMS];
    logic signed [COORD_BITS-1:0] coords    [MAX_DIMS];
    logic [SQ_BITS-1:0]           sq        [MAX_DIMS];
    logic [MAX_DIMS-1:0]          lane_on;
    logic [DIST_BITS-1:0]         cand_sq;

    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [FUNC_BITS-1:0] s1_op_reg, s2_op_reg, s3_op_reg;
    logic [ID_BITS-1:0]   s1_id_reg, s2_id_reg, s3_id_reg;

    logic advance;
    logic accept;
    logic retire;
    logic list_clear;
    logic list_insert;
    logic rep_load;
    logic rep_free;

    knn_entry_t               entries [MAX_NEIGHBORS];
    logic [MAX_NEIGHBORS-1:0] list_valid_vec;

    assign coords[0] = item.coord0;
    assign coords[1] = item.coord1;
    assign coords[2] = item.coord2;
    assign coords[3] = item.coord3;
    assign coords[4] = item.coord4;
    assign coords[5] = item.coord5;
    assign coords[6] = item.coord6;
    assign coords[7] = item.coord7;

    always_comb
    begin
        dims_eff = eff_dims(dims_reg);
        k_eff    = eff_k(k_reg);
        k_last   = RANK_BITS'(k_eff - K_BITS'(1));
        for (int i = 0; i < MAX_DIMS; i++)
            lane_on[i] = DIMS_BITS'(i) < dims_eff;

        // Only a report waiting on a busy report buffer holds the pipeline.
        advance     = !(s3_valid_reg && s3_op_reg == FUNC_REPORT && !rep_free);
        item_ready  = advance;
        accept      = item_valid && advance;
        retire      = advance && s3_valid_reg;
        list_clear  = (cfg_write && cfg_index == CFG_NEIGHBORS)
                      || (retire && s3_op_reg == FUNC_QUERY);
        list_insert = retire && s3_op_reg == FUNC_CAND && cand_sq != '0;
        rep_load    = retire && s3_op_reg == FUNC_REPORT;

        for (int i = 0; i < MAX_NEIGHBORS; i++)
            list_valid_vec[i] = entries[i].valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= DIMS_BITS'(MAX_DIMS);
            k_reg    <= K_BITS'(MAX_NEIGHBORS);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DIMS:      dims_reg <= cfg_data[DIMS_BITS-1:0];
                CFG_NEIGHBORS: k_reg    <= cfg_data[K_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // The query is loaded at acceptance so that a candidate right behind it sees it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DIMS; i++)
                query_reg[i] <= '0;
        end
        else if (accept && item.func == FUNC_QUERY)
        begin
            query_reg <= coords;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg <= item.func;
            s1_id_reg <= item.point_id;
            s2_op_reg <= s1_op_reg;
            s2_id_reg <= s1_id_reg;
            s3_op_reg <= s2_op_reg;
            s3_id_reg <= s2_id_reg;
        end
    end

    for (genvar g = 0; g < MAX_DIMS; g++)
    begin : g_lane
        knn_dist_lane u_lane (
            .clk     (clk),
            .advance (advance),
            .lane_on (lane_on[g]),
            .coord   (coords[g]),
            .query   (query_reg[g]),
            .sq_reg  (sq[g])
        );
    end

    knn_sum_tree u_sum (
        .clk      (clk),
        .advance  (advance),
        .sq       (sq),
        .dist_reg (cand_sq)
    );

    knn_topk_list u_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (list_clear),
        .insert    (list_insert),
        .cand_id   (s3_id_reg),
        .cand_dist (cand_sq),
        .k_last    (k_last),
        .entries   (entries)
    );

    knn_report u_report (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (rep_load),
        .entries      (entries),
        .k_last       (k_last),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result),
        .free         (rep_free)
    );

    // Filled entries always form a prefix of the list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (list_valid_vec & (list_valid_vec + 1'b1)) == '0)
        else $error("neighbor list has a gap");

    assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (s3_valid_reg && s3_op_reg == FUNC_REPORT && !rep_free))
        else $error("pipeline stalled without a blocked report");

    assert property (@(posedge clk) disable iff (!rst_n)
        rep_load |=> (result_valid && result.rank == '0))
        else $error("report run did not start at rank zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && cfg_index == CFG_NEIGHBORS) |=> (list_valid_vec == '0))
        else $error("list not emptied after neighbor count write");

endmodule

`default_nettype wire

// ===== verif/tb_knn_topk_distance_insert_unit.sv =====
// Self-checking testbench for the k-nearest-neighbor top-k distance insert unit.
`timescale 1ns / 1ps

module tb_knn_topk_distance_insert_unit;
    import knn_pkg::*;

    localparam int IDLE_PCT      = 23;
    localparam int RAND_PHASES   = 7;
    localparam int PHASE_ITEMS   = 38;
    localparam int CALM_PHASE    = 4;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 20;
    localparam int HOLD_AT       = 70;
    localparam int HOLD_CYCLES   = 120;
    localparam int MAX_SHOWN     = 10;
    localparam int LIMIT_NS      = 400000;

    localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [DIST_BITS-1:0] FAR_SQ      = 35'd34358689800;

    typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

    typedef struct {
        step_kind_t           kind;
        knn_item_t            req;
        logic                 cfg_idx;
        logic [CFG_BITS-1:0]  cfg_val;
        logic                 typed;
        logic                 top_valid;
        logic [ID_BITS-1:0]   top_id;
        logic [DIST_BITS-1:0] top_sq;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic                cfg_index = 1'b0;
    logic [CFG_BITS-1:0] cfg_data = '0;
    logic                item_valid = 1'b0;
    logic                item_ready;
    knn_item_t           item = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    knn_result_t         result;

    bit                  calm = 1'b0;
    int unsigned         fail_count = 0;
    plan_row_t           plan[$];
    knn_result_t         expected_entries[$];

    // Mirror of the block's state.
    logic signed [COORD_BITS-1:0] q_coord [MAX_DIMS];
    logic                         near_valid [MAX_NEIGHBORS];
    logic [ID_BITS-1:0]           near_id [MAX_NEIGHBORS];
    logic [DIST_BITS:0]           near_sq [MAX_NEIGHBORS];
    logic [DIMS_BITS-1:0]         dims_reg;
    logic [K_BITS-1:0]            k_reg;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    knn_topk_distance_insert_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Coordinate 0 sits in the most significant coordinate slot of the packed request.
    function automatic logic signed [COORD_BITS-1:0] coord_at(input knn_item_t it, input int idx);
        return it[(MAX_DIMS-1-idx)*COORD_BITS +: COORD_BITS];
    endfunction

    function automatic knn_item_t put_coord(input knn_item_t it, input int idx,
                                            input logic [COORD_BITS-1:0] v);
        knn_item_t o;
        o = it;
        o[(MAX_DIMS-1-idx)*COORD_BITS +: COORD_BITS] = v;
        return o;
    endfunction

    function automatic knn_item_t mk_item(input logic [FUNC_BITS-1:0] f,
                                          input logic [ID_BITS-1:0] id,
                                          input logic [COORD_BITS-1:0] c0,
                                          input logic [COORD_BITS-1:0] rest);
        knn_item_t it;
        int        i;
        it = '0;
        it.func = f;
        it.point_id = id;
        it = put_coord(it, 0, c0);
        for (i = 1; i < MAX_DIMS; i++)
            it = put_coord(it, i, rest);
        return it;
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic knn_item_t random_query();
        knn_item_t it;
        int        i;
        it = mk_item(FUNC_QUERY, 24'($urandom()), '0, '0);
        for (i = 0; i < MAX_DIMS; i++)
            it = put_coord(it, i, rand_coord());
        return it;
    endfunction

    function automatic plan_row_t item_row(input knn_item_t it);
        plan_row_t row;
        row = '{STEP_ITEM, it, CFG_DIMS, '0, 1'b0, 1'b0, '0, '0};
        return row;
    endfunction

    function automatic int unsigned dims_used();
        if (dims_reg == 0)
            return 1;
        if (dims_reg > MAX_DIMS)
            return MAX_DIMS;
        return dims_reg;
    endfunction

    function automatic int unsigned k_used();
        if (k_reg == 0)
            return 1;
        if (k_reg > MAX_NEIGHBORS)
            return MAX_NEIGHBORS;
        return k_reg;
    endfunction

    task automatic empty_list();
        int i;
        for (i = 0; i < MAX_NEIGHBORS; i++)
        begin
            near_valid[i] = 1'b0;
            near_id[i] = '0;
            near_sq[i] = '0;
        end
    endtask

    // Applies one accepted request to the mirrored list and queues the entries it reports.
    task automatic update_neighbor_list(input knn_item_t it);
        int unsigned i, k, pos;
        longint      diff, acc;
        logic [DIST_BITS:0] sq;
        knn_result_t e;
        k = k_used();
        if (it.func == FUNC_QUERY)
        begin
            for (i = 0; i < MAX_DIMS; i++)
                q_coord[i] = coord_at(it, i);
            empty_list();
        end
        else if (it.func == FUNC_CAND)
        begin
            acc = 0;
            for (i = 0; i < dims_used(); i++)
            begin
                diff = longint'(coord_at(it, i)) - longint'(q_coord[i]);
                acc += diff * diff;
            end
            sq = acc[DIST_BITS:0];
            // A candidate sitting on the query is skipped; ties go behind equal entries.
            if (acc != 0 && !(near_valid[k-1] && sq >= near_sq[k-1]))
            begin
                pos = k - 1;
                for (i = 0; i + 1 < k; i++)
                begin
                    if (!near_valid[i] || near_sq[i] > sq)
                    begin
                        pos = i;
                        break;
                    end
                end
                for (i = k - 1; i > pos; i--)
                begin
                    near_valid[i] = near_valid[i-1];
                    near_id[i] = near_id[i-1];
                    near_sq[i] = near_sq[i-1];
                end
                near_valid[pos] = 1'b1;
                near_id[pos] = it.point_id;
                near_sq[pos] = sq;
            end
        end
        else if (it.func == FUNC_REPORT)
        begin
            for (i = 0; i < k; i++)
            begin
                e.rank = RANK_BITS'(i);
                e.neighbor_id = near_valid[i] ? near_id[i] : '0;
                e.neighbor_sq_dist = near_valid[i] ? near_sq[i][DIST_BITS-1:0] : '0;
                e.neighbor_valid = near_valid[i];
                e.last = (i + 1 == k);
                expected_entries.push_back(e);
            end
        end
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("mismatch: %s", msg);
    endtask

    task automatic add_item(input knn_item_t it);
        plan.push_back(item_row(it));
    endtask

    task automatic add_typed(input logic hit, input logic [ID_BITS-1:0] id,
                             input logic [DIST_BITS-1:0] sq);
        plan_row_t row;
        row = item_row(mk_item(FUNC_REPORT, '0, '0, '0));
        row.typed = 1'b1;
        row.top_valid = hit;
        row.top_id = id;
        row.top_sq = sq;
        plan.push_back(row);
    endtask

    task automatic add_cfg(input logic idx, input logic [CFG_BITS-1:0] val);
        plan_row_t row;
        row = '{STEP_CFG, '0, idx, val, 1'b0, 1'b0, '0, '0};
        plan.push_back(row);
    endtask

    // Called and returning at a falling edge; valid stays high after acceptance.
    task automatic send_request(input plan_row_t row);
        int unsigned i, k;
        knn_result_t e;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= row.req;
        do
            @(posedge clk);
        while (!item_ready);
        if (row.typed)
        begin
            // Typed report: at most the nearest entry is filled, the rest are empty.
            k = k_used();
            for (i = 0; i < k; i++)
            begin
                e = '0;
                e.rank = RANK_BITS'(i);
                if (i == 0 && row.top_valid)
                begin
                    e.neighbor_id = row.top_id;
                    e.neighbor_sq_dist = row.top_sq;
                    e.neighbor_valid = 1'b1;
                end
                e.last = (i + 1 == k);
                expected_entries.push_back(e);
            end
        end
        else
            update_neighbor_list(row.req);
        @(negedge clk);
    endtask

    // Registers change only with the block idle and every reported entry received.
    task automatic settle();
        item_valid <= 1'b0;
        while (expected_entries.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_BITS-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == CFG_DIMS)
            dims_reg = val[DIMS_BITS-1:0];
        else
        begin
            k_reg = val;
            empty_list();
        end
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : result_sink
        knn_result_t want;
        int unsigned hold_left;
        int unsigned taken;
        bit          held;
        hold_left = 0;
        taken = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left != 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else
                result_ready <= (calm || $urandom_range(99) >= IDLE_PCT);
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                taken++;
                if (expected_entries.size() == 0)
                    note_failure($sformatf("entry rank %0d with nothing expected", result.rank));
                else
                begin
                    want = expected_entries.pop_front();
                    if (result.rank !== want.rank)
                        note_failure($sformatf("rank: expected %0d, got %0d",
                                               want.rank, result.rank));
                    if (result.neighbor_id !== want.neighbor_id)
                        note_failure($sformatf("rank %0d neighbor_id: expected %h, got %h",
                                               want.rank, want.neighbor_id, result.neighbor_id));
                    if (result.neighbor_sq_dist !== want.neighbor_sq_dist)
                        note_failure($sformatf("rank %0d neighbor_sq_dist: expected %0d, got %0d",
                                               want.rank, want.neighbor_sq_dist,
                                               result.neighbor_sq_dist));
                    if (result.neighbor_valid !== want.neighbor_valid)
                        note_failure($sformatf("rank %0d neighbor_valid: expected %b, got %b",
                                               want.rank, want.neighbor_valid,
                                               result.neighbor_valid));
                    if (result.last !== want.last)
                        note_failure($sformatf("rank %0d last: expected %b, got %b",
                                               want.rank, want.last, result.last));
                end
                // One long stall so that reports back up and the request side stops.
                if (!held && taken >= HOLD_AT)
                begin
                    held = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned         phase, n, r, m, i;
        logic [CFG_BITS-1:0] dims_val, k_val;
        knn_item_t           it, prev_cand;

        for (i = 0; i < MAX_DIMS; i++)
            q_coord[i] = '0;
        empty_list();
        dims_reg = DIMS_BITS'(MAX_DIMS);
        k_reg = K_BITS'(MAX_NEIGHBORS);

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: extremes, ties, skipped candidates and register clamping.
        add_typed(1'b0, '0, '0);
        add_cfg(CFG_NEIGHBORS, 5'd2);
        add_item(mk_item(FUNC_QUERY, 24'd0, 16'h8000, 16'h8000));
        add_item(mk_item(FUNC_CAND, 24'hFFFFFF, 16'h7FFF, 16'h7FFF));
        add_typed(1'b1, 24'hFFFFFF, FAR_SQ);
        add_item(mk_item(FUNC_CAND, 24'h000123, 16'h8000, 16'h8000));
        add_item(mk_item(FUNC_CAND, 24'd0, 16'h8001, 16'h8000));
        add_item(mk_item(FUNC_CAND, 24'd5, 16'h8001, 16'h8000));
        add_item(mk_item(FUNC_CAND, 24'd6, 16'h8001, 16'h8000));
        add_item(mk_item(FUNC_REPORT, 24'd0, 16'h0000, 16'h0000));
        add_item(mk_item(FUNC_UNUSED, 24'hFFFFFF, 16'h1234, 16'hFEDC));
        add_cfg(CFG_DIMS, 5'd0);
        add_item(mk_item(FUNC_QUERY, 24'd0, 16'h0000, 16'h7FFF));
        add_item(mk_item(FUNC_CAND, 24'hABCDEF, 16'h0003, 16'h8000));
        add_item(mk_item(FUNC_CAND, 24'd7, 16'h0000, 16'h0064));
        add_typed(1'b1, 24'hABCDEF, 35'd9);
        add_cfg(CFG_DIMS, 5'd31);
        add_cfg(CFG_NEIGHBORS, 5'd0);
        add_item(mk_item(FUNC_CAND, 24'd8, 16'h0001, 16'h7FFF));
        add_item(mk_item(FUNC_CAND, 24'd9, 16'h0002, 16'h7FFF));
        add_typed(1'b1, 24'd8, 35'd1);
        add_cfg(CFG_NEIGHBORS, 5'd31);
        add_item(mk_item(FUNC_QUERY, 24'd0, 16'h4000, 16'hC000));
        add_item(mk_item(FUNC_CAND, 24'h555555, 16'h3FFF, 16'hC000));
        add_item(mk_item(FUNC_CAND, 24'hAAAAAA, 16'h4000, 16'hC001));
        add_item(mk_item(FUNC_CAND, 24'h000001, 16'h4001, 16'hC000));
        add_item(mk_item(FUNC_REPORT, 24'd0, 16'h0000, 16'h0000));
        add_cfg(CFG_NEIGHBORS, 5'd16);
        add_cfg(CFG_DIMS, 5'd8);

        foreach (plan[j])
        begin
            if (plan[j].kind == STEP_CFG)
            begin
                settle();
                write_reg(plan[j].cfg_idx, plan[j].cfg_val);
            end
            else
                send_request(plan[j]);
        end

        // Random part: each phase is a new setting, a query, then mostly candidates.
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            settle();
            if (phase == 1)
            begin
                dims_val = 5'd8;
                k_val = 5'd16;
            end
            else if (phase == 2)
            begin
                dims_val = 5'd1;
                k_val = 5'd1;
            end
            else
            begin
                dims_val = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                                    : 5'($urandom_range(1, 8));
                k_val = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                                 : 5'($urandom_range(1, 16));
            end
            if ($urandom_range(1))
            begin
                write_reg(CFG_DIMS, dims_val);
                write_reg(CFG_NEIGHBORS, k_val);
            end
            else
            begin
                write_reg(CFG_NEIGHBORS, k_val);
                write_reg(CFG_DIMS, dims_val);
            end
            calm <= (phase == CALM_PHASE);

            it = random_query();
            prev_cand = it;
            send_request(item_row(it));
            for (n = 2; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(99);
                if (r < 70)
                begin
                    it = mk_item(FUNC_CAND, 24'($urandom()), '0, '0);
                    m = $urandom_range(3);
                    for (i = 0; i < MAX_DIMS; i++)
                    begin
                        case (m)
                            0: it = put_coord(it, i, rand_coord());
                            1: it = put_coord(it, i, q_coord[i] + 16'($urandom_range(4)) - 16'd2);
                            2: it = put_coord(it, i, coord_at(prev_cand, i));
                            default: it = put_coord(it, i,
                                                    q_coord[i] + 16'($urandom_range(2000)) - 16'd1000);
                        endcase
                    end
                    prev_cand = it;
                end
                else if (r < 84)
                    it = mk_item(FUNC_REPORT, 24'($urandom()), 16'($urandom()), 16'($urandom()));
                else if (r < 90)
                    it = random_query();
                else if (r < 95)
                begin
                    it = random_query();
                    it.func = FUNC_UNUSED;
                end
                else
                begin
                    // On the query in every dimension in use, anywhere beyond.
                    it = mk_item(FUNC_CAND, 24'($urandom()), '0, '0);
                    for (i = 0; i < MAX_DIMS; i++)
                        it = put_coord(it, i, (i < dims_used()) ? q_coord[i] : rand_coord());
                end
                send_request(item_row(it));
            end
            send_request(item_row(mk_item(FUNC_REPORT, 24'($urandom()),
                                          16'($urandom()), 16'($urandom()))));
            calm <= 1'b0;
        end

        settle();
        repeat (END_CYCLES) @(negedge clk);
        if (expected_entries.size() != 0)
            note_failure($sformatf("%0d entries never reported", expected_entries.size()));
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/knn_pkg.sv
rtl/knn_dist_lane.sv
rtl/knn_sum_tree.sv
rtl/knn_topk_list.sv
rtl/knn_report.sv
rtl/knn_topk_distance_insert_unit.sv
verif/tb_knn_topk_distance_insert_unit.sv
